// ===== src/ktt_pkg.sv =====
// Shared types and codes for the keyed timer table.
`timescale 1ns / 1ps
`default_nettype none

package ktt_pkg;

	// Function codes of an input transaction
	localparam logic FUNC_ADD  = 1'b0;
	localparam logic FUNC_TICK = 1'b1;

	// Result kinds
	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_EXPIRY = 1'b1;

	// Add status codes
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_NULL_KEY = 2'd1;
	localparam logic [1:0] STATUS_FULL     = 2'd2;

	// Field widths fixed by the interface
	localparam int unsigned DEADLINE_W = 32;
	localparam int unsigned TAG_W      = 32;
	localparam int unsigned LEN_W      = 16;

	typedef struct packed {
		logic        func;
		logic [7:0]  client_key;
		logic [15:0] timeout_seconds;
		logic [31:0] payload_tag;
		logic [15:0] payload_length;
	} ktt_in_t;

	typedef struct packed {
		logic        result_kind;
		logic [1:0]  add_status;
		logic [7:0]  expired_key;
		logic [31:0] expired_tag;
		logic [15:0] expired_length;
		logic        last_of_run;
	} ktt_out_t;

	// Controller to datapath
	typedef struct packed {
		logic start;
		logic step;
		logic finish;
	} ktt_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic req_null;
		logic tick;
		logic pend_v;
		logic out_free;
		logic hold;
		logic last_idx;
	} ktt_sts_t;

endpackage

`default_nettype wire

// ===== src/keyed_timer_table.sv =====
// Keyed one-shot timer table: one add or tick transaction at a time, slots scanned in order.
// An add answers with a status after a scan of every slot, a null-key add without a scan.
// A tick scans one slot per cycle from the slot memory read port, stalled while an expiry
// waits on a full result register; the next transaction is accepted after the scan ends.
// Reset clears the seconds count and frees every slot at once, no clear pass.
`timescale 1ns / 1ps
`default_nettype none

module keyed_timer_table #(
	parameter int unsigned SLOTS    = 16,
	parameter int unsigned KEY_BITS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire ktt_pkg::ktt_in_t  req,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output ktt_pkg::ktt_out_t      rsp
);

	ktt_pkg::ktt_cmd_t cmd;
	ktt_pkg::ktt_sts_t sts;

	ktt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	ktt_datapath #(
		.SLOTS    (SLOTS),
		.KEY_BITS (KEY_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// ===== src/ktt_ctrl.sv =====
// Sequencing state machine of the keyed timer table.
`timescale 1ns / 1ps
`default_nettype none

module ktt_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	input  wire ktt_pkg::ktt_sts_t sts,
	output ktt_pkg::ktt_cmd_t      cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRIME,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t state_q;

	// Drive commands from the current state
	always_comb begin
		req_ready  = (state_q == ST_IDLE);
		cmd.start  = req_valid && (state_q == ST_IDLE);
		cmd.step   = (state_q == ST_SCAN) && !sts.hold;
		cmd.finish = (state_q == ST_FINISH) && (sts.out_free || (sts.tick && !sts.pend_v));
	end

	// Advance state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= sts.req_null ? ST_FINISH : ST_PRIME;
					end
				end
				ST_PRIME: begin
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (cmd.step && sts.last_idx) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					if (cmd.finish) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/ktt_datapath.sv =====
// Slot memory, scan index, clock count and result register of the keyed timer table.
`timescale 1ns / 1ps
`default_nettype none

module ktt_datapath #(
	parameter int unsigned SLOTS    = 16,
	parameter int unsigned KEY_BITS = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ktt_pkg::ktt_in_t  req,
	input  wire ktt_pkg::ktt_cmd_t cmd,
	output ktt_pkg::ktt_sts_t      sts,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	output ktt_pkg::ktt_out_t      rsp
);

	localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned DL_W  = ktt_pkg::DEADLINE_W;
	localparam int unsigned TAG_W = ktt_pkg::TAG_W;
	localparam int unsigned LEN_W = ktt_pkg::LEN_W;
	localparam int unsigned REC_W = KEY_BITS + DL_W + TAG_W + LEN_W;

	// Slot record memory: key, deadline, tag, length
	logic [REC_W-1:0] mem [SLOTS];
	logic [REC_W-1:0] rd_q;

	logic [DL_W-1:0]     seconds_q;
	logic                req_func_q;
	logic                req_null_q;
	logic [KEY_BITS-1:0] req_key_q;
	logic [15:0]         req_timeout_q;
	logic [TAG_W-1:0]    req_tag_q;
	logic [LEN_W-1:0]    req_len_q;

	logic [IDX_W-1:0] idx_q;
	logic             match_v_q;
	logic [IDX_W-1:0] match_idx_q;
	logic             free_v_q;
	logic [IDX_W-1:0] free_idx_q;

	logic             pend_v_q;
	logic [7:0]       pend_key_q;
	logic [TAG_W-1:0] pend_tag_q;
	logic [LEN_W-1:0] pend_len_q;

	logic [SLOTS-1:0] active_q;
	logic [SLOTS-1:0] written_q;

	logic              rsp_valid_q;
	ktt_pkg::ktt_out_t rsp_q;

	logic [KEY_BITS-1:0] in_key;
	logic                last_idx;
	logic [IDX_W-1:0]    idx_nxt;
	logic [IDX_W-1:0]    rd_addr;
	logic [KEY_BITS-1:0] rd_key;
	logic [DL_W-1:0]     rd_deadline;
	logic [TAG_W-1:0]    rd_tag;
	logic [LEN_W-1:0]    rd_len;
	logic [DL_W-1:0]     diff;
	logic                expired_here;
	logic                key_hit;
	logic                out_free;
	logic                found;
	logic [IDX_W-1:0]    pick;
	logic                do_write;
	logic                emit_pend;
	ktt_pkg::ktt_out_t   emit_val;
	logic                emit;

	// Decode the incoming key and the scan position
	always_comb begin
		in_key      = KEY_BITS'(req.client_key);
		last_idx    = (idx_q == IDX_W'(SLOTS - 1));
		idx_nxt     = last_idx ? '0 : idx_q + 1'b1;
		rd_addr     = cmd.step ? idx_nxt : idx_q;
		rd_key      = rd_q[REC_W-1 -: KEY_BITS];
		rd_deadline = rd_q[DL_W+TAG_W+LEN_W-1 -: DL_W];
		rd_tag      = rd_q[TAG_W+LEN_W-1 -: TAG_W];
		rd_len      = rd_q[LEN_W-1:0];
	end

	// Evaluate the slot under the scan index
	always_comb begin
		diff         = seconds_q - rd_deadline;
		expired_here = (req_func_q == ktt_pkg::FUNC_TICK) && active_q[idx_q] && !diff[DL_W-1];
		key_hit      = written_q[idx_q] && (rd_key == req_key_q);
		out_free     = !rsp_valid_q || rsp_ready;
		found        = match_v_q || free_v_q;
		pick         = match_v_q ? match_idx_q : free_idx_q;
		do_write     = cmd.finish && (req_func_q == ktt_pkg::FUNC_ADD) && !req_null_q && found;
		emit_pend    = cmd.step && expired_here && pend_v_q;
	end

	// Select the result to load
	always_comb begin
		emit_val = '0;
		emit     = 1'b0;
		if (emit_pend) begin
			emit_val.result_kind    = ktt_pkg::KIND_EXPIRY;
			emit_val.expired_key    = pend_key_q;
			emit_val.expired_tag    = pend_tag_q;
			emit_val.expired_length = pend_len_q;
			emit                    = 1'b1;
		end else if (cmd.finish) begin
			if (req_func_q == ktt_pkg::FUNC_TICK) begin
				emit_val.result_kind    = ktt_pkg::KIND_EXPIRY;
				emit_val.expired_key    = pend_key_q;
				emit_val.expired_tag    = pend_tag_q;
				emit_val.expired_length = pend_len_q;
				emit_val.last_of_run    = 1'b1;
				emit                    = pend_v_q;
			end else begin
				emit_val.result_kind = ktt_pkg::KIND_STATUS;
				emit_val.last_of_run = 1'b1;
				if (req_null_q) begin
					emit_val.add_status = ktt_pkg::STATUS_NULL_KEY;
				end else if (found) begin
					emit_val.add_status = ktt_pkg::STATUS_OK;
				end else begin
					emit_val.add_status = ktt_pkg::STATUS_FULL;
				end
				emit = 1'b1;
			end
		end
	end

	// Report status to the controller
	always_comb begin
		sts.req_null = (req.func == ktt_pkg::FUNC_ADD) && (in_key == '0);
		sts.tick     = (req_func_q == ktt_pkg::FUNC_TICK);
		sts.pend_v   = pend_v_q;
		sts.out_free = out_free;
		sts.hold     = expired_here && pend_v_q && !out_free;
		sts.last_idx = last_idx;
	end

	// Write the chosen slot and read the next one
	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[pick] <= {req_key_q, seconds_q + DL_W'(req_timeout_q), req_tag_q, req_len_q};
		end
		rd_q <= mem[rd_addr];
	end

	// Capture the transaction payload
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			req_func_q    <= req.func;
			req_null_q    <= sts.req_null;
			req_key_q     <= in_key;
			req_timeout_q <= req.timeout_seconds;
			req_tag_q     <= req.payload_tag;
			req_len_q     <= req.payload_length;
		end
	end

	// Hold the expiry waiting for a successor
	always_ff @(posedge clk) begin
		if (cmd.step && expired_here) begin
			pend_key_q <= 8'(rd_key);
			pend_tag_q <= rd_tag;
			pend_len_q <= rd_len;
		end
	end

	// Advance clock count, scan index and search results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seconds_q   <= '0;
			idx_q       <= '0;
			match_v_q   <= 1'b0;
			match_idx_q <= '0;
			free_v_q    <= 1'b0;
			free_idx_q  <= '0;
			pend_v_q    <= 1'b0;
			active_q    <= '0;
			written_q   <= '0;
		end else begin
			if (cmd.start) begin
				if (req.func == ktt_pkg::FUNC_TICK) begin
					seconds_q <= seconds_q + 1'b1;
				end
				idx_q     <= '0;
				match_v_q <= 1'b0;
				free_v_q  <= 1'b0;
				pend_v_q  <= 1'b0;
			end
			if (cmd.step) begin
				idx_q <= idx_nxt;
				if (req_func_q == ktt_pkg::FUNC_ADD) begin
					if (!match_v_q && key_hit) begin
						match_v_q   <= 1'b1;
						match_idx_q <= idx_q;
					end
					if (!free_v_q && !active_q[idx_q]) begin
						free_v_q   <= 1'b1;
						free_idx_q <= idx_q;
					end
				end else if (expired_here) begin
					active_q[idx_q] <= 1'b0;
					pend_v_q        <= 1'b1;
				end
			end
			if (do_write) begin
				active_q[pick]  <= 1'b1;
				written_q[pick] <= 1'b1;
			end
			if (cmd.finish) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= emit_val;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire
